[src/spq_pkg.sv]
`default_nettype none

package spq_pkg;

   // Operation codes carried in the request.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_SERVE = 1'b1;

   // Status codes returned with every response.
   localparam logic [1:0] ST_ADDED  = 2'd0;
   localparam logic [1:0] ST_SERVED = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [15:0] process_id;
      logic [7:0]  priority_req;
   } spq_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] served_id;
      logic [7:0]  served_priority;
      logic [4:0]  waiting_count;
   } spq_rsp_type;

   // Row-wide command broadcast to every cell.
   typedef struct packed {
      logic add;
      logic serve;
   } spq_cell_ctrl_type;

endpackage

`default_nettype wire

[src/stable_priority_queue.sv]
`default_nettype none

// Stable priority queue built as a row of CAPACITY cells kept sorted by
// ascending priority value, with the head in cell 0. A transaction either adds
// an entry, which lands behind every waiting entry of equal or lower priority
// value, or serves the head. Every cell compares its priority with the new one
// in the same cycle and either holds, loads the new entry or takes its
// neighbor's entry, so one transaction is taken on every clock cycle and busy
// never rises. Each transaction produces exactly one response, presented on
// rsp_data for a single cycle with rsp_valid high on the cycle after the
// transaction is accepted. The receiver cannot stall the response, so it must
// capture it on that cycle. An add to a full queue is rejected with the full
// status and a serve of an empty queue returns the empty status; neither
// changes the contents. The served identifier and priority read zero unless
// the status is served, and waiting_count is the occupancy after the
// transaction.

module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY      = 16,
   parameter int ID_BITS       = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire spq_req_type req_data,
   output logic             busy,
   output logic             rsp_valid,
   output spq_rsp_type      rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff;
   spq_rsp_type   rsp_ff, rsp_in;

   logic              accept;
   logic              full;
   logic              empty;
   spq_cell_ctrl_type ctrl;

   logic [ID_BITS-1:0]       new_id;
   logic [PRIORITY_BITS-1:0] new_pri;

   logic [ID_BITS-1:0]       cell_id   [CAPACITY];
   logic [PRIORITY_BITS-1:0] cell_pri  [CAPACITY];
   logic [CAPACITY-1:0]      cell_after;
   logic [CAPACITY-1:0]      occupied;

   // busy is tied low: the block never stalls, so it is always ready.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign full  = (count_ff == CW'(CAPACITY));
   assign empty = (count_ff == '0);

   assign new_id  = ID_BITS'(req_data.process_id);
   assign new_pri = PRIORITY_BITS'(req_data.priority_req);

   // Rejected operations leave the row untouched.
   assign ctrl.add   = accept && (req_data.operation == OP_ADD) && !full;
   assign ctrl.serve = accept && (req_data.operation == OP_SERVE) && !empty;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [ID_BITS-1:0]       l_id, r_id;
         logic [PRIORITY_BITS-1:0] l_pri, r_pri;
         logic                     l_after;

         assign occupied[g] = (CW'(g) < count_ff);

         // The head cell sees a virtual neighbor that always lies ahead of
         // the new entry; the tail cell refills from itself on a serve,
         // which only ever affects an unoccupied slot.
         if (g == 0) begin : g_head
            assign l_id    = new_id;
            assign l_pri   = new_pri;
            assign l_after = 1'b1;
         end else begin : g_body
            assign l_id    = cell_id[g-1];
            assign l_pri   = cell_pri[g-1];
            assign l_after = cell_after[g-1];
         end

         if (g == CAPACITY - 1) begin : g_tail
            assign r_id  = cell_id[g];
            assign r_pri = cell_pri[g];
         end else begin : g_inner
            assign r_id  = cell_id[g+1];
            assign r_pri = cell_pri[g+1];
         end

         spq_cell #(
            .IDW (ID_BITS),
            .PW  (PRIORITY_BITS)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .occupied   (occupied[g]),
            .new_id     (new_id),
            .new_pri    (new_pri),
            .left_id    (l_id),
            .left_pri   (l_pri),
            .left_after (l_after),
            .right_id   (r_id),
            .right_pri  (r_pri),
            .id_out     (cell_id[g]),
            .pri_out    (cell_pri[g]),
            .after_out  (cell_after[g])
         );
      end
   endgenerate

   // Occupancy follows the accepted adds and serves.
   always_comb begin
      count_in = count_ff;
      if (ctrl.add) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.serve) begin
         count_in = count_ff - CW'(1);
      end
   end

   // The response is assembled from the head cell before it shifts out.
   always_comb begin
      rsp_in                 = '0;
      rsp_in.waiting_count   = 5'(count_in);
      if (req_data.operation == OP_ADD) begin
         rsp_in.status = full ? ST_FULL : ST_ADDED;
      end else if (empty) begin
         rsp_in.status = ST_EMPTY;
      end else begin
         rsp_in.status          = ST_SERVED;
         rsp_in.served_id       = 16'(cell_id[0]);
         rsp_in.served_priority = 8'(cell_pri[0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

[src/spq_cell.sv]
`default_nettype none

module spq_cell
   import spq_pkg::*;
#(
   parameter int IDW = 16,
   parameter int PW  = 8
) (
   input  wire logic              clock,
   input  wire spq_cell_ctrl_type ctrl,
   input  wire logic              occupied,
   input  wire logic [IDW-1:0]    new_id,
   input  wire logic [PW-1:0]     new_pri,
   input  wire logic [IDW-1:0]    left_id,
   input  wire logic [PW-1:0]     left_pri,
   input  wire logic              left_after,
   input  wire logic [IDW-1:0]    right_id,
   input  wire logic [PW-1:0]     right_pri,
   output logic [IDW-1:0]         id_out,
   output logic [PW-1:0]          pri_out,
   output logic                   after_out
);

   logic [IDW-1:0] id_ff, id_in;
   logic [PW-1:0]  pri_ff, pri_in;

   // The new entry belongs behind this cell when this cell holds an entry
   // whose priority is not larger; equal priorities stay first in, first out.
   assign after_out = occupied && (pri_ff <= new_pri);

   always_comb begin
      id_in  = id_ff;
      pri_in = pri_ff;
      if (ctrl.add) begin
         if (!after_out && left_after) begin
            id_in  = new_id;
            pri_in = new_pri;
         end else if (!after_out) begin
            id_in  = left_id;
            pri_in = left_pri;
         end
      end else if (ctrl.serve) begin
         id_in  = right_id;
         pri_in = right_pri;
      end
   end

   always_ff @(posedge clock) begin
      id_ff  <= id_in;
      pri_ff <= pri_in;
   end

   assign id_out  = id_ff;
   assign pri_out = pri_ff;

endmodule

`default_nettype wire
